>>> rtl/core/pssr_pkg.sv
// Shared types and constants for the slot status responder.
package pssr_pkg;

	localparam logic [3:0] CMD_TICK    = 4'd0;
	localparam logic [3:0] CMD_STATUS  = 4'd1;
	localparam logic [3:0] CMD_QUERY   = 4'd2;
	localparam logic [3:0] CMD_WRITE   = 4'd3;
	localparam logic [3:0] CMD_LOAD    = 4'd4;
	localparam logic [3:0] CMD_UNLOAD  = 4'd5;
	localparam logic [3:0] CMD_CLEAR   = 4'd6;
	localparam logic [3:0] CMD_A       = 4'd7;
	localparam logic [3:0] CMD_R       = 4'd8;
	localparam logic [3:0] CMD_J       = 4'd9;
	localparam logic [3:0] CMD_M       = 4'd10;

	localparam logic [2:0] RK_STATUS = 3'd0;
	localparam logic [2:0] RK_QUERY  = 3'd1;
	localparam logic [2:0] RK_WACK   = 3'd2;
	localparam logic [2:0] RK_A      = 3'd3;
	localparam logic [2:0] RK_R      = 3'd4;
	localparam logic [2:0] RK_J      = 3'd5;
	localparam logic [2:0] RK_M      = 3'd6;
	localparam logic [2:0] RK_ERR    = 3'd7;

	localparam logic [3:0] TIMER_MAX    = 4'd15;
	localparam logic [3:0] FINAL_OFFSET = 4'd5;

	// Back-end operations chosen by the front end.
	localparam logic [2:0] OP_REPORT = 3'd0;
	localparam logic [2:0] OP_QUERY  = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_SLOT   = 3'd3;
	localparam logic [2:0] OP_FIXED  = 3'd4;

	typedef struct packed {
		logic [2:0]   op;
		logic [3:0]   cmd;
		logic [3:0]   slot;
		logic         slot_ok;
		logic         blk_ok;
		logic [7:0]   blk;
		logic [2:0]   kind;
		logic [7:0]   b1;
		logic [7:0]   b2;
		logic [7:0]   b3;
		logic [127:0] wdata;
	} pssr_req_t;

endpackage

>>> rtl/core/portal_slot_status_responder_unit.sv
// Top level of the portal slot status responder.
//
// channel | handshake          | payload
// in      | in_valid/in_ready  | command slot echo_in block wr_low wr_high
// out     | out_valid/out_ready| reply_kind reply_byte_* rd_low rd_high slot_codes report_number
//
// A request is written into a two-entry queue in the front end at the edge it is
// accepted; the back end takes it once it is ready and registers any reply. A block
// query's reply is registered only after its store read, which is registered too,
// returns. The figure store has a single port, read through a register.
// Reset clears the queue, slot flags, timers and report counter; the store is not cleared.
// A stalled reply holds the back end; the queue keeps taking requests until full.
module portal_slot_status_responder_unit import pssr_pkg::*; #(
	parameter int SLOT_COUNT = 16,
	parameter int BLOCKS_PER_FIGURE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  command,
	input  logic [3:0]  slot,
	input  logic [7:0]  echo_in,
	input  logic [7:0]  block,
	input  logic [63:0] wr_low,
	input  logic [63:0] wr_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  reply_kind,
	output logic [7:0]  reply_byte_one,
	output logic [7:0]  reply_byte_two,
	output logic [7:0]  reply_byte_three,
	output logic [63:0] rd_low,
	output logic [63:0] rd_high,
	output logic [31:0] slot_codes,
	output logic [7:0]  report_number
);
	logic      q_valid, q_ready;
	pssr_req_t q_req;

	// Classify requests and hold them in the queue.
	pssr_front #(.SLOT_COUNT(SLOT_COUNT), .BLOCKS_PER_FIGURE(BLOCKS_PER_FIGURE)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .command, .slot, .echo_in, .block,
		.wr_low, .wr_high, .q_valid, .q_ready, .q_req
	);

	// Carry requests out and drive the reply register.
	pssr_back #(.SLOT_COUNT(SLOT_COUNT), .BLOCKS_PER_FIGURE(BLOCKS_PER_FIGURE)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req, .out_valid, .out_ready,
		.reply_kind, .reply_byte_one, .reply_byte_two, .reply_byte_three,
		.rd_low, .rd_high, .slot_codes, .report_number
	);

	// A queued request is not taken while the reply waits and cannot be replaced.
	a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !q_ready)
		else $error("request taken while reply stalled");

	// An in-range block query presents its reply once the back end takes it and its store read returns.
	a_query_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && q_req.op == OP_QUERY && q_req.slot_ok && q_req.blk_ok)
		|=> ##1 (out_valid && reply_kind == RK_QUERY))
		else $error("query reply missing");

	// A reply held by the sink keeps its kind.
	a_reply_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(reply_kind)))
		else $error("stalled reply changed");
endmodule

>>> rtl/core/pssr_front.sv
// Front end: accept and classify host requests into a two-entry queue.
module pssr_front import pssr_pkg::*; #(
	parameter int SLOT_COUNT = 16,
	parameter int BLOCKS_PER_FIGURE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  command,
	input  logic [3:0]  slot,
	input  logic [7:0]  echo_in,
	input  logic [7:0]  block,
	input  logic [63:0] wr_low,
	input  logic [63:0] wr_high,
	output logic        q_valid,
	input  logic        q_ready,
	output pssr_req_t   q_req
);
	pssr_req_t req_c;
	pssr_req_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      push, pop;

	always_comb begin
		req_c = '0;
		req_c.cmd = command;
		req_c.slot = slot;
		req_c.blk = block;
		req_c.wdata = {wr_high, wr_low};
		req_c.slot_ok = ({1'b0, slot} < 5'(SLOT_COUNT));
		req_c.blk_ok = ({1'b0, block} < 9'(BLOCKS_PER_FIGURE));
		req_c.op = OP_FIXED;
		case (command)
			CMD_TICK, CMD_STATUS: req_c.op = OP_REPORT;
			CMD_QUERY:            req_c.op = OP_QUERY;
			CMD_WRITE:            req_c.op = OP_WRITE;
			CMD_LOAD, CMD_UNLOAD, CMD_CLEAR: req_c.op = OP_SLOT;
			CMD_A: begin
				req_c.kind = RK_A; req_c.b1 = echo_in; req_c.b2 = 8'hFF; req_c.b3 = 8'h77;
			end
			CMD_R: begin
				req_c.kind = RK_R; req_c.b1 = 8'h02; req_c.b2 = 8'h18;
			end
			CMD_J: req_c.kind = RK_J;
			CMD_M: begin
				req_c.kind = RK_M; req_c.b1 = echo_in; req_c.b3 = 8'h19;
			end
			default: req_c.op = OP_SLOT; // unused codes: no reply, slot decode ignores them
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= req_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> rtl/core/pssr_back.sv
// Back end: slot state, figure store and reply register.
module pssr_back import pssr_pkg::*; #(
	parameter int SLOT_COUNT = 16,
	parameter int BLOCKS_PER_FIGURE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_ready,
	input  pssr_req_t    q_req,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   reply_kind,
	output logic [7:0]   reply_byte_one,
	output logic [7:0]   reply_byte_two,
	output logic [7:0]   reply_byte_three,
	output logic [63:0]  rd_low,
	output logic [63:0]  rd_high,
	output logic [31:0]  slot_codes,
	output logic [7:0]   report_number
);
	localparam int BW = (BLOCKS_PER_FIGURE > 1) ? $clog2(BLOCKS_PER_FIGURE) : 1;
	localparam int DEPTH = SLOT_COUNT * BLOCKS_PER_FIGURE;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [127:0] store_q [DEPTH];
	logic [127:0] rdata_q;
	logic [15:0]  present_q;
	logic [3:0]   timer_q [16];
	logic [7:0]   counter_q;
	logic         busy_q;      // store read in flight
	logic         full_q;
	logic [AW-1:0] addr;
	logic [31:0]  codes_c;
	logic         moving_c;
	logic         take, addr_ok, send;

	assign addr = AW'(({8'd0, q_req.slot} * 12'(BLOCKS_PER_FIGURE)) + 12'(q_req.blk[BW-1:0]));
	assign addr_ok = q_req.slot_ok && q_req.blk_ok;
	assign out_valid = full_q;
	// Accept a request only when the reply register is free or being taken and no read is pending.
	assign q_ready = !busy_q && (!full_q || out_ready);
	assign take = q_valid && q_ready;

	always_comb begin
		codes_c = '0;
		moving_c = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (i < SLOT_COUNT) begin
				if (present_q[i])
					codes_c[2*i +: 2] = (timer_q[i] >= TIMER_MAX - FINAL_OFFSET) ? 2'b01 : 2'b11;
				else
					codes_c[2*i +: 2] = (timer_q[i] <= FINAL_OFFSET) ? 2'b00 : 2'b10;
				if (timer_q[i] != 4'd0 && timer_q[i] != TIMER_MAX) moving_c = 1'b1;
			end
		end
	end
	assign send = (q_req.cmd == CMD_STATUS) || moving_c;

	always_ff @(posedge clk) begin
		if (take && q_req.op == OP_WRITE && addr_ok) store_q[addr] <= q_req.wdata;
		if (take && q_req.op == OP_QUERY) rdata_q <= store_q[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int i = 0; i < 16; i++) timer_q[i] <= '0;
			counter_q <= '0;
			busy_q <= 1'b0;
			full_q <= 1'b0;
			reply_kind <= '0; reply_byte_one <= '0; reply_byte_two <= '0;
			reply_byte_three <= '0; rd_low <= '0; rd_high <= '0;
			slot_codes <= '0; report_number <= '0;
		end else begin
			if (full_q && out_ready && !busy_q) full_q <= 1'b0;
			if (busy_q) begin
				// Read data is back: present the query reply.
				busy_q <= 1'b0;
				full_q <= 1'b1;
				rd_low <= rdata_q[63:0];
				rd_high <= rdata_q[127:64];
			end
			if (take) begin
				reply_byte_one <= '0; reply_byte_two <= '0; reply_byte_three <= '0;
				rd_low <= '0; rd_high <= '0; slot_codes <= '0; report_number <= '0;
				case (q_req.op)
					OP_REPORT: begin
						for (int i = 0; i < 16; i++) begin
							if (present_q[i])
								timer_q[i] <= (timer_q[i] < TIMER_MAX) ? timer_q[i] + 4'd1 : TIMER_MAX;
							else
								timer_q[i] <= (timer_q[i] > 4'd0) ? timer_q[i] - 4'd1 : 4'd0;
						end
						if (send) begin
							full_q <= 1'b1;
							reply_kind <= RK_STATUS;
							slot_codes <= codes_c;
							report_number <= counter_q;
							counter_q <= counter_q + 8'd1;
						end
					end
					OP_QUERY, OP_WRITE: begin
						reply_byte_one <= {4'h1, q_req.slot};
						reply_byte_two <= q_req.blk;
						if (!addr_ok) begin
							full_q <= 1'b1;
							reply_kind <= RK_ERR;
						end else if (q_req.op == OP_QUERY) begin
							busy_q <= 1'b1;
							full_q <= 1'b0;
							reply_kind <= RK_QUERY;
						end else begin
							full_q <= 1'b1;
							reply_kind <= RK_WACK;
						end
					end
					OP_SLOT: begin
						if (q_req.slot_ok) begin
							case (q_req.cmd)
								CMD_LOAD: begin
									timer_q[q_req.slot] <= 4'd0; present_q[q_req.slot] <= 1'b1;
								end
								CMD_UNLOAD: begin
									timer_q[q_req.slot] <= TIMER_MAX; present_q[q_req.slot] <= 1'b0;
								end
								CMD_CLEAR: present_q[q_req.slot] <= 1'b0;
								default: ;
							endcase
						end
					end
					default: begin
						full_q <= 1'b1;
						reply_kind <= q_req.kind;
						reply_byte_one <= q_req.b1;
						reply_byte_two <= q_req.b2;
						reply_byte_three <= q_req.b3;
					end
				endcase
			end
		end
	end
endmodule
